/* hdl/bpcrc_pkg.sv */
// Package: shared constants for the boot page CRC-32 stamper.
`default_nettype none
package bpcrc_pkg;

	localparam int unsigned PAGE_BYTES = 256;
	localparam int unsigned BOOT_BYTES_DEF = 256;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [7:0] LAST_POS = 8'(PAGE_BYTES - 1);

endpackage
`default_nettype wire

/* hdl/boot_page_crc32_stamper.sv */
// Top level: boot page CRC-32 stamper with valid/ready byte channels.
`default_nettype none
// Passes page bytes through one per cycle unless out_ready stalls the output. On a page that
// starts with boot_page set while stamp_enable is 1, it runs CRC-32/MPEG-2 (poly 04C11DB7,
// init all ones, MSB first, no final XOR) over the first BOOT_BYTES-4 bytes and replaces the
// next four with the CRC, low byte first. first_of_page restarts the byte count and CRC;
// stamp_enable is sampled on that byte. Throughput is one byte per cycle when not stalled;
// the byte-wide CRC XOR tree lies between the input byte and the CRC register, and the
// output register takes a new byte in the same cycle that its held byte is taken.
module boot_page_crc32_stamper #(
	parameter int unsigned BOOT_BYTES = bpcrc_pkg::BOOT_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       stamp_enable_we,
	input  wire logic       stamp_enable,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_of_page,
	input  wire logic       boot_page,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] out_byte,
	output logic            page_end
);
	import bpcrc_pkg::*;

	localparam logic [8:0] BootLim = 9'(BOOT_BYTES);
	localparam logic [8:0] SlotLim = 9'(BOOT_BYTES - 4);

	logic        stamp_enable_q;
	logic [31:0] crc_q;
	logic [7:0]  byte_pos_q;
	logic        stamping_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        page_end_q;

	logic        accept;
	logic        stamp_cur;
	logic [7:0]  pos_cur;
	logic [31:0] crc_cur;
	logic [31:0] crc_upd;
	logic        in_crc;
	logic        in_slot;
	logic [1:0]  slot_k;
	logic [7:0]  ob;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Restart count and CRC on the first byte of a page.
	assign stamp_cur = first_of_page ? (boot_page && stamp_enable_q) : stamping_q;
	assign pos_cur   = first_of_page ? 8'd0 : byte_pos_q;
	assign crc_cur   = first_of_page ? CRC_INIT : crc_q;

	assign in_crc  = stamp_cur && ({1'b0, pos_cur} < SlotLim);
	assign in_slot = stamp_cur && !({1'b0, pos_cur} < SlotLim) && ({1'b0, pos_cur} < BootLim);
	assign slot_k  = pos_cur[1:0] - SlotLim[1:0];

	bpcrc_crc_step u_crc (
		.crc_in  (crc_cur),
		.data    (data_byte),
		.crc_out (crc_upd)
	);

	always_comb begin
		ob = data_byte;
		if (in_slot) begin
			case (slot_k)
				2'd0:    ob = crc_cur[7:0];
				2'd1:    ob = crc_cur[15:8];
				2'd2:    ob = crc_cur[23:16];
				default: ob = crc_cur[31:24];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_enable_q <= 1'b1;
			crc_q          <= CRC_INIT;
			byte_pos_q     <= 8'd0;
			stamping_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (stamp_enable_we) begin
				stamp_enable_q <= stamp_enable;
			end
			if (accept) begin
				crc_q       <= in_crc ? crc_upd : crc_cur;
				byte_pos_q  <= pos_cur + 8'd1;
				stamping_q  <= stamp_cur;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= ob;
			page_end_q <= (pos_cur == LAST_POS);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign page_end  = page_end_q;

`ifndef SYNTHESIS
	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item not presented");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !first_of_page && !stamping_q |=> out_byte == $past(data_byte))
		else $error("unstamped byte altered");

	a_page_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !first_of_page && byte_pos_q == LAST_POS |=> page_end)
		else $error("page end missed");
`endif

endmodule
`default_nettype wire

/* hdl/bpcrc_crc_step.sv */
// Byte-wide CRC-32/MPEG-2 update: MSB first, no reflection.
`default_nettype none
module bpcrc_crc_step (
	input  wire logic [31:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [31:0] crc_out
);
	import bpcrc_pkg::*;

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {data, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire
